### hw/rtl/cube_map_face_uv_select_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cube map face select block
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CUBE_MAP_FACE_UV_SELECT_MACROS_SVH
`define CUBE_MAP_FACE_UV_SELECT_MACROS_SVH

`ifndef SYNTHESIS

// Property holds at every clock edge outside reset.
`define CMF_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("cube map face select: check failed");

// Consequent holds in the cycle after the antecedent.
`define CMF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cube map face select: next-cycle check failed");

`else

`define CMF_ASSERT(label, clk, rst, prop)
`define CMF_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### hw/rtl/cmfuv_pkg.sv
// ----------------------------------------------------------------------------
// Cube map face select package
// Face codes shared by the block and its users.
// ----------------------------------------------------------------------------
package cmfuv_pkg;

  typedef enum logic [2:0] {
    FACE_POS_X = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_Y = 3'd2,
    FACE_NEG_Y = 3'd3,
    FACE_POS_Z = 3'd4,
    FACE_NEG_Z = 3'd5
  } face_t;

endpackage

### hw/rtl/cube_map_face_uv_select.sv
// ----------------------------------------------------------------------------
// Cube map face and coordinate select
// Picks the major-axis face of a direction vector and maps the two
// face-local coordinates into unsigned fixed point through a pipelined
// restoring divider.
// ----------------------------------------------------------------------------
//
//   channel | signals                                   | dir
//   --------+-------------------------------------------+-----
//   input   | in_valid, in_stall, dir_x, dir_y, dir_z    | in
//   output  | out_valid, out_stall, face_index, tex_u,   | out
//           | tex_v, zero_direction                     |
//
// One transaction enters per cycle while no result is held at the output.
// The depth is set by the divider, which retires one quotient bit per
// fraction stage (COORD_WIDTH - 1 fraction stages after one integer
// stage that yields the integer part).
// Reset clears all valid bits together; no clearing pass is needed.
// A stalled result holds the whole pipeline in place; bubbles ahead of it
// keep flowing in only when the output side moves.
//
`include "cube_map_face_uv_select_macros.svh"

module cube_map_face_uv_select #(
  parameter int COMPONENT_WIDTH = 16,
  parameter int COORD_WIDTH     = 16
) (
  input  logic                       clk,
  input  logic                       rst,

  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [COMPONENT_WIDTH-1:0] dir_x,
  input  logic [COMPONENT_WIDTH-1:0] dir_y,
  input  logic [COMPONENT_WIDTH-1:0] dir_z,

  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 face_index,
  output logic [COORD_WIDTH-1:0]     tex_u,
  output logic [COORD_WIDTH-1:0]     tex_v,
  output logic                       zero_direction
);

  import cmfuv_pkg::*;

  localparam int CW = COMPONENT_WIDTH;
  localparam int CO = COORD_WIDTH;
  // Fraction stages of the divider.
  localparam int NF = CO - 1;
  // Quotient width: two integer bits plus NF fraction bits.
  localparam int QW = CO + 1;
  // abs, select, offset, integer divide, NF fraction stages, output.
  localparam int NS = CO + 4;

  // --------------------------------------------------------------------------
  // Pipeline control: one enable for every stage. Advance unless the result
  // at the output is held by the consumer.
  // --------------------------------------------------------------------------
  logic          en;
  logic [NS-1:0] vld;

  assign en       = !(vld[NS-1] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], in_valid};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: hold the components and their magnitudes. The most negative
  // value maps to 2^(CW-1), which still fits an unsigned CW-bit word.
  // --------------------------------------------------------------------------
  logic [CW-1:0] s1_x, s1_y, s1_z;
  logic [CW-1:0] s1_ax, s1_ay, s1_az;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x  <= dir_x;
      s1_y  <= dir_y;
      s1_z  <= dir_z;
      s1_ax <= dir_x[CW-1] ? ((~dir_x) + CW'(1)) : dir_x;
      s1_ay <= dir_y[CW-1] ? ((~dir_y) + CW'(1)) : dir_y;
      s1_az <= dir_z[CW-1] ? ((~dir_z) + CW'(1)) : dir_z;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: pick the face. Z beats Y beats X on ties; a zero component
  // counts as negative. Coordinates are kept as CW+1 bit two's complement
  // so that negating the most negative value does not wrap.
  // --------------------------------------------------------------------------
  logic [CW:0]   xe, ye, ze, xn, zn;
  logic          x_pos, y_pos, z_pos;
  logic          sel_y, sel_z;
  logic [CW-1:0] m_sel;
  logic [CW:0]   sc_sel, tc_sel;
  face_t         face_sel;

  assign xe    = {s1_x[CW-1], s1_x};
  assign ye    = {s1_y[CW-1], s1_y};
  assign ze    = {s1_z[CW-1], s1_z};
  assign xn    = (~xe) + (CW+1)'(1);
  assign zn    = (~ze) + (CW+1)'(1);
  assign x_pos = !s1_x[CW-1] && (|s1_x);
  assign y_pos = !s1_y[CW-1] && (|s1_y);
  assign z_pos = !s1_z[CW-1] && (|s1_z);
  assign sel_z = (s1_az >= s1_ax) && (s1_az >= s1_ay);
  assign sel_y = (s1_ay >= s1_ax) && (s1_ay >= s1_az);

  always_comb begin
    priority if (sel_z) begin
      m_sel    = s1_az;
      tc_sel   = ye;
      sc_sel   = z_pos ? xe : xn;
      face_sel = z_pos ? FACE_POS_Z : FACE_NEG_Z;
    end else if (sel_y) begin
      m_sel    = s1_ay;
      sc_sel   = xe;
      tc_sel   = y_pos ? zn : ze;
      face_sel = y_pos ? FACE_POS_Y : FACE_NEG_Y;
    end else begin
      m_sel    = s1_ax;
      tc_sel   = ye;
      sc_sel   = x_pos ? zn : ze;
      face_sel = x_pos ? FACE_POS_X : FACE_NEG_X;
    end
  end

  logic [CW-1:0] s2_m;
  logic [CW:0]   s2_sc, s2_tc;
  face_t         s2_face;
  logic          s2_zero;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_m    <= m_sel;
      s2_sc   <= sc_sel;
      s2_tc   <= tc_sel;
      s2_face <= face_sel;
      s2_zero <= (m_sel == '0);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: offset each coordinate by the major magnitude. The true value
  // lies in [0, 2m], so the sum wraps harmlessly in CW+1 bits.
  // --------------------------------------------------------------------------
  logic [CW-1:0] s3_m;
  logic [CW:0]   s3_nu, s3_nv;
  face_t         s3_face;
  logic          s3_zero;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_m    <= s2_m;
      s3_nu   <= s2_sc + {1'b0, s2_m};
      s3_nv   <= s2_tc + {1'b0, s2_m};
      s3_face <= s2_face;
      s3_zero <= s2_zero;
    end
  end

  // --------------------------------------------------------------------------
  // Divider. Index 0 holds the integer part (0, 1 or 2, as n <= 2m); each
  // following index retires one fraction bit for both coordinates.
  // --------------------------------------------------------------------------
  logic [CW-1:0] dm   [0:NF];
  logic [CW-1:0] dru  [0:NF];
  logic [CW-1:0] drv  [0:NF];
  logic [QW-1:0] dqu  [0:NF];
  logic [QW-1:0] dqv  [0:NF];
  face_t         dface[0:NF];
  logic          dzero[0:NF];

  logic [CW:0]   m_ext, m_dbl;
  logic [CW:0]   nu_sub, nv_sub;

  assign m_ext  = {1'b0, s3_m};
  assign m_dbl  = {s3_m, 1'b0};
  assign nu_sub = s3_nu - m_ext;
  assign nv_sub = s3_nv - m_ext;

  always_ff @(posedge clk) begin
    if (en) begin
      dm[0]    <= s3_m;
      dface[0] <= s3_face;
      dzero[0] <= s3_zero;
      priority if (s3_nu >= m_dbl) begin
        dqu[0] <= QW'(2);
        dru[0] <= '0;
      end else if (s3_nu >= m_ext) begin
        dqu[0] <= QW'(1);
        dru[0] <= nu_sub[CW-1:0];
      end else begin
        dqu[0] <= '0;
        dru[0] <= s3_nu[CW-1:0];
      end
      priority if (s3_nv >= m_dbl) begin
        dqv[0] <= QW'(2);
        drv[0] <= '0;
      end else if (s3_nv >= m_ext) begin
        dqv[0] <= QW'(1);
        drv[0] <= nv_sub[CW-1:0];
      end else begin
        dqv[0] <= '0;
        drv[0] <= s3_nv[CW-1:0];
      end
    end
  end

  for (genvar k = 0; k < NF; k++) begin : g_frac
    logic [CW:0] ru2, rv2, mk, ru_sub, rv_sub;
    logic        bu, bv;

    // Shift the partial remainder up, subtract the divisor when it fits.
    assign ru2    = {dru[k], 1'b0};
    assign rv2    = {drv[k], 1'b0};
    assign mk     = {1'b0, dm[k]};
    assign ru_sub = ru2 - mk;
    assign rv_sub = rv2 - mk;
    assign bu     = (ru2 >= mk);
    assign bv     = (rv2 >= mk);

    always_ff @(posedge clk) begin
      if (en) begin
        dm[k+1]    <= dm[k];
        dface[k+1] <= dface[k];
        dzero[k+1] <= dzero[k];
        dqu[k+1]   <= {dqu[k][QW-2:0], bu};
        dqv[k+1]   <= {dqv[k][QW-2:0], bv};
        dru[k+1]   <= bu ? ru_sub[CW-1:0] : ru2[CW-1:0];
        drv[k+1]   <= bv ? rv_sub[CW-1:0] : rv2[CW-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: saturate a quotient of exactly two to all ones, and force
  // the all-zero direction to face -Z with zero coordinates.
  // --------------------------------------------------------------------------
  logic [CO-1:0] sat_u, sat_v;

  assign sat_u = dqu[NF][CO] ? '1 : dqu[NF][CO-1:0];
  assign sat_v = dqv[NF][CO] ? '1 : dqv[NF][CO-1:0];

  face_t         out_face;
  logic [CO-1:0] out_u, out_v;
  logic          out_zero;

  always_ff @(posedge clk) begin
    if (en) begin
      out_face <= dzero[NF] ? FACE_NEG_Z : dface[NF];
      out_u    <= dzero[NF] ? '0 : sat_u;
      out_v    <= dzero[NF] ? '0 : sat_v;
      out_zero <= dzero[NF];
    end
  end

  assign out_valid      = vld[NS-1];
  assign face_index     = out_face;
  assign tex_u          = out_u;
  assign tex_v          = out_v;
  assign zero_direction = out_zero;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `CMF_ASSERT(a_zero_forces_result, clk, rst, (out_valid && zero_direction) |-> ((face_index == FACE_NEG_Z) && (tex_u == '0) && (tex_v == '0)))
  `CMF_ASSERT_NEXT(a_stall_freezes_pipe, clk, rst, (out_valid && out_stall), $stable(vld))
  `CMF_ASSERT(a_divisor_nonzero, clk, rst, (vld[3] && !dzero[0]) |-> (dm[0] != '0))
  `CMF_ASSERT(a_quotient_bounded, clk, rst, (vld[NS-2] && !dzero[NF] && dqu[NF][CO]) |-> (dqu[NF][CO-1:0] == '0))

endmodule

### tb/face_uv_checker.sv
// ----------------------------------------------------------------------------
// Cube map face select checker
// Watches both channels of the face select block, predicts the face and the
// two unit coordinates of every accepted direction, and compares each result
// transaction with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module face_uv_checker #(
  parameter int DIR_W   = 16,
  parameter int COORD_W = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [DIR_W-1:0]   dir_x,
  input  logic [DIR_W-1:0]   dir_y,
  input  logic [DIR_W-1:0]   dir_z,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [2:0]         face_index,
  input  logic [COORD_W-1:0] tex_u,
  input  logic [COORD_W-1:0] tex_v,
  input  logic               zero_direction,
  output int                 mismatch_count,
  output int                 outstanding
);

  import cmfuv_pkg::*;

  typedef struct packed {
    face_t              face;
    logic [COORD_W-1:0] u;
    logic [COORD_W-1:0] v;
    logic               zero;
  } texel_t;

  texel_t pending_texels[$];
  int     errors_seen;

  // floor((c + span) * 2^(COORD_W-1) / span), clipped to the top code
  function automatic logic [COORD_W-1:0] unit_coord(longint c, longint span);
    longint q;
    q = ((c + span) <<< (COORD_W - 1)) / span;
    if (q > longint'((64'd1 << COORD_W) - 1)) return '1;
    return q[COORD_W-1:0];
  endfunction

  // Later axis tests override earlier ones, so ties go Z over Y over X
  function automatic texel_t project_direction(logic signed [DIR_W-1:0] x,
                                               logic signed [DIR_W-1:0] y,
                                               logic signed [DIR_W-1:0] z);
    texel_t r;
    longint sx, sy, sz, ax, ay, az, span, hc, vc;
    sx = x;
    sy = y;
    sz = z;
    ax = (sx < 0) ? -sx : sx;
    ay = (sy < 0) ? -sy : sy;
    az = (sz < 0) ? -sz : sz;
    r.face = FACE_NEG_Z;
    span = 0;
    hc = 0;
    vc = 0;
    if (ax >= ay && ax >= az) begin
      span = ax;
      vc = sy;
      if (sx > 0) begin
        hc = -sz;
        r.face = FACE_POS_X;
      end else begin
        hc = sz;
        r.face = FACE_NEG_X;
      end
    end
    if (ay >= ax && ay >= az) begin
      span = ay;
      hc = sx;
      if (sy > 0) begin
        vc = -sz;
        r.face = FACE_POS_Y;
      end else begin
        vc = sz;
        r.face = FACE_NEG_Y;
      end
    end
    if (az >= ax && az >= ay) begin
      span = az;
      vc = sy;
      if (sz > 0) begin
        hc = sx;
        r.face = FACE_POS_Z;
      end else begin
        hc = -sx;
        r.face = FACE_NEG_Z;
      end
    end
    if (span == 0) begin
      r.face = FACE_NEG_Z;
      r.u = '0;
      r.v = '0;
      r.zero = 1'b1;
    end else begin
      r.u = unit_coord(hc, span);
      r.v = unit_coord(vc, span);
      r.zero = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    texel_t want;
    if (rst) begin
      pending_texels.delete();
    end else begin
      if (in_valid && !in_stall)
        pending_texels.push_back(project_direction(dir_x, dir_y, dir_z));
      if (out_valid && !out_stall) begin
        if (pending_texels.size() == 0) begin
          if (errors_seen < 10)
            $display("%0t: unexpected result face=%0d u=%0d v=%0d zero=%0b",
                     $realtime, face_index, tex_u, tex_v, zero_direction);
          errors_seen++;
        end else begin
          want = pending_texels.pop_front();
          if (face_index !== want.face || tex_u !== want.u || tex_v !== want.v ||
              zero_direction !== want.zero) begin
            if (errors_seen < 10)
              $display("%0t: want face=%0d u=%0d v=%0d z=%0b, got %0d %0d %0d %0b",
                       $realtime, want.face, want.u, want.v, want.zero,
                       face_index, tex_u, tex_v, zero_direction);
            errors_seen++;
          end
        end
      end
    end
    mismatch_count <= errors_seen;
    outstanding    <= pending_texels.size();
  end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Cube map face select testbench
// Drives directed and random direction vectors into the face select block
// with random gaps and stalls on both channels, a long output hold-off and a
// full drain pause; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import cmfuv_pkg::*;

  localparam int DIR_W        = 16;
  localparam int COORD_W      = 16;
  // matches the stage count of the block's pipeline
  localparam int LATENCY      = COORD_W + 4;
  localparam int RANDOM_ITEMS = 1250;
  localparam int JAM_CYCLES   = 300;
  localparam int LIMIT_CYCLES = 200000;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               out_stall = 1'b0;
  logic [DIR_W-1:0]   dir_x = '0;
  logic [DIR_W-1:0]   dir_y = '0;
  logic [DIR_W-1:0]   dir_z = '0;
  logic               in_stall;
  logic               out_valid;
  logic [2:0]         face_index;
  logic [COORD_W-1:0] tex_u;
  logic [COORD_W-1:0] tex_v;
  logic               zero_direction;

  int mismatch_count;
  int outstanding;

  // calm: no idling on either side; jam_req: ask the receiver for one long hold
  logic calm = 1'b0;
  logic jam_req = 1'b0;
  bit   jam_done = 1'b0;
  int   held;
  int   cycles = 0;

  cube_map_face_uv_select #(
    .COMPONENT_WIDTH(DIR_W),
    .COORD_WIDTH    (COORD_W)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .dir_x         (dir_x),
    .dir_y         (dir_y),
    .dir_z         (dir_z),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .face_index    (face_index),
    .tex_u         (tex_u),
    .tex_v         (tex_v),
    .zero_direction(zero_direction)
  );

  face_uv_checker #(
    .DIR_W  (DIR_W),
    .COORD_W(COORD_W)
  ) face_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .dir_x         (dir_x),
    .dir_y         (dir_y),
    .dir_z         (dir_z),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .face_index    (face_index),
    .tex_u         (tex_u),
    .tex_v         (tex_v),
    .zero_direction(zero_direction),
    .mismatch_count(mismatch_count),
    .outstanding   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop: count edges and give up well past the slowest legal run.
  initial begin
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL cube_map_face_uv_select");
    $finish;
  end

  // Receiver: stall at random outside calm stretches. When the stimulus asks
  // for it, hold off once for a long stretch so the pipeline fills and the
  // block backs up into its input channel.
  initial begin
    forever begin
      @(posedge clk);
      if (jam_req && !jam_done) begin
        jam_done = 1'b1;
        for (held = 0; held < JAM_CYCLES; held++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= !calm && ($urandom_range(99) < 21);
    end
  end

  // Offer one direction transaction, with random gaps ahead of it; hold the
  // payload until the block takes it. Valid stays high into the next call,
  // so back-to-back transactions never drop valid within a step.
  task automatic offer(input logic [DIR_W-1:0] x, input logic [DIR_W-1:0] y,
                       input logic [DIR_W-1:0] z);
    while (!calm && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    dir_x    <= x;
    dir_y    <= y;
    dir_z    <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted result has come back. The
  // first edge lets the checker count a transaction taken at this one.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Random direction with a mix of shapes: plain random words, small values
  // that tie often, forced magnitude ties, extreme components, sparse
  // vectors and scaled-down vectors that keep the major magnitude small.
  task automatic pick_direction(output logic [DIR_W-1:0] x,
                                output logic [DIR_W-1:0] y,
                                output logic [DIR_W-1:0] z);
    logic [31:0] r;
    x = DIR_W'($urandom);
    y = DIR_W'($urandom);
    z = DIR_W'($urandom);
    case ($urandom_range(9))
      5: begin
        x = DIR_W'($urandom_range(8)) - DIR_W'(4);
        y = DIR_W'($urandom_range(8)) - DIR_W'(4);
        z = DIR_W'($urandom_range(8)) - DIR_W'(4);
      end
      6: begin
        r = $urandom;
        case ($urandom_range(3))
          0: y = r[0] ? x : -x;
          1: z = r[0] ? x : -x;
          2: z = r[0] ? y : -y;
          default: begin
            y = r[0] ? x : -x;
            z = r[1] ? x : -x;
          end
        endcase
      end
      7: begin
        r = $urandom;
        case ($urandom_range(2))
          0: x = r[0] ? 16'h8000 : 16'h7FFF;
          1: y = r[0] ? 16'h8000 : 16'h7FFF;
          default: z = r[0] ? 16'h8000 : 16'h7FFF;
        endcase
      end
      8: begin
        r = $urandom;
        if (r[0]) x = '0;
        if (r[1]) y = '0;
        if (r[2]) z = '0;
      end
      9: begin
        x = $signed(x) >>> $urandom_range(15);
        y = $signed(y) >>> $urandom_range(15);
        z = $signed(z) >>> $urandom_range(15);
      end
      default: ;
    endcase
  endtask

  initial begin
    int n;
    logic [DIR_W-1:0] vx, vy, vz;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero vector, one vector per face, ties, extremes.
    offer(16'd0, 16'd0, 16'd0);
    offer(16'd1000, 16'd300, -16'd200);
    offer(-16'd1000, -16'd300, 16'd200);
    offer(16'd300, 16'd1000, -16'd200);
    offer(-16'd300, -16'd1000, 16'd200);
    offer(16'd300, -16'd200, 16'd1000);
    offer(-16'd300, 16'd200, -16'd1000);
    // unit axes and zero components, which count as negative
    offer(16'd1, 16'd0, 16'd0);
    offer(16'd0, -16'd1, 16'd0);
    offer(16'd0, 16'd0, 16'd1);
    offer(16'd0, 16'd0, -16'd1);
    // magnitude ties, including full ties where a coordinate hits one
    offer(16'd500, -16'd500, 16'd7);
    offer(16'd9, 16'd500, -16'd500);
    offer(-16'd500, 16'd9, 16'd500);
    offer(16'd500, 16'd500, 16'd500);
    offer(-16'd1, 16'd1, -16'd1);
    // most negative and most positive components
    offer(16'h8000, 16'h8000, 16'h8000);
    offer(16'h7FFF, 16'h7FFF, 16'h7FFF);
    offer(16'h7FFF, 16'h8000, 16'd0);
    offer(16'h8000, 16'h7FFF, 16'h7FFF);
    offer(16'h7FFF, 16'h8000, 16'h8000);
    offer(16'hFFFF, 16'h8001, 16'h7FFE);
    offer(16'h0001, 16'hFFFF, 16'h8000);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      // a stretch with no idling on either side
      if (n == 300) calm <= 1'b1;
      if (n == 550) calm <= 1'b0;
      // long receiver hold while the sender keeps offering
      if (n == 650) jam_req <= 1'b1;
      // sender pause until every result is back
      if (n == 800) drain();
      pick_direction(vx, vy, vz);
      offer(vx, vy, vz);
    end

    drain();
    repeat (2 * LATENCY) @(posedge clk);

    if (mismatch_count == 0 && outstanding == 0)
      $display("PASS cube_map_face_uv_select");
    else
      $display("FAIL cube_map_face_uv_select");
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/cmfuv_pkg.sv
hw/rtl/cube_map_face_uv_select.sv
tb/face_uv_checker.sv
tb/testbench.sv
